// ===== rtl/btc_pkg.sv =====
// Shared types and constants for the barometric temperature compensation block.
// Used by the interfaces, controller, datapath and top level. No dependencies.
`timescale 1ns / 1ps

package btc_pkg;

    // Widths of the sample and result fields, the trim words and the config index.
    localparam int ADC_W  = 20;
    localparam int DATA_W = 32;
    localparam int TRIM_W = 48;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_TRIM    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TRIM_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TRIM_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TRIM_C = 3'd3;

    // Sample tag codes.
    localparam logic CMD_TEMP  = 1'b0;
    localparam logic CMD_PRESS = 1'b1;

    // Sequencer step codes: four temperature steps, then the pressure steps.
    typedef logic [4:0] step_t;
    localparam step_t ST_T0  = 5'd0;
    localparam step_t ST_T1  = 5'd1;
    localparam step_t ST_T2  = 5'd2;
    localparam step_t ST_T3  = 5'd3;
    localparam step_t ST_P0  = 5'd4;
    localparam step_t ST_P1  = 5'd5;
    localparam step_t ST_P2  = 5'd6;
    localparam step_t ST_P3  = 5'd7;
    localparam step_t ST_P4  = 5'd8;
    localparam step_t ST_P5  = 5'd9;
    localparam step_t ST_P6  = 5'd10;
    localparam step_t ST_P7  = 5'd11;
    localparam step_t ST_P8  = 5'd12;
    localparam step_t ST_P9  = 5'd13;
    localparam step_t ST_P10 = 5'd14;
    localparam step_t ST_P11 = 5'd15;
    localparam step_t ST_P12 = 5'd16;
    localparam step_t ST_P13 = 5'd17;

    // Compensation constants.
    localparam logic [DATA_W-1:0] K_T_OFFSET  = 32'd64000;
    localparam logic [DATA_W-1:0] K_ADC_SPAN  = 32'd1048576;
    localparam logic [DATA_W-1:0] K_P_SCALE   = 32'd3125;
    localparam logic [DATA_W-1:0] K_P1_OFFSET = 32'd32768;
    localparam logic [DATA_W-1:0] K_T_ROUND   = 32'd128;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  exec;
        step_t step;
        logic  div_start;
        logic  div_capture;
        logic  out_load;
    } btc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic zero;
        logic div_done;
    } btc_stat_t;

    // Arithmetic right shift of a 32-bit two's-complement pattern.
    function automatic logic [DATA_W-1:0] sra(input logic [DATA_W-1:0] v,
                                              input int unsigned n);
        logic signed [DATA_W-1:0] s;
        s = $signed(v);
        return $unsigned(s >>> n);
    endfunction

    // Sign extension of a 16-bit trim word.
    function automatic logic [DATA_W-1:0] sx16(input logic [15:0] w);
        return {{(DATA_W-16){w[15]}}, w};
    endfunction

endpackage

// ===== rtl/btc_if.sv =====
// Word channel interfaces for samples and results.
// Depends on btc_pkg for the field widths.
`timescale 1ns / 1ps

interface btc_sample_if;
    import btc_pkg::*;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [ADC_W-1:0]  raw_adc;
    modport source (output valid, output cmd, output raw_adc, input ready);
    modport sink   (input valid, input cmd, input raw_adc, output ready);
endinterface

interface btc_result_if;
    import btc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [DATA_W-1:0] temperature_centi;
    logic [DATA_W-1:0]        pressure_pa;
    logic                     zero_divisor;
    modport source (output valid, output kind, output temperature_centi,
                    output pressure_pa, output zero_divisor, input ready);
    modport sink   (input valid, input kind, input temperature_centi,
                    input pressure_pa, input zero_divisor, output ready);
endinterface

// ===== rtl/btc_div.sv =====
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// Depends on btc_pkg for the data width.
`timescale 1ns / 1ps

module btc_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [btc_pkg::DATA_W-1:0] dividend,
    input  logic [btc_pkg::DATA_W-1:0] divisor,
    output logic                   done,
    output logic [btc_pkg::DATA_W-1:0] quotient
);
    import btc_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic [DATA_W:0]   trial;

    // One shift-and-subtract step per cycle.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quo_reg[DATA_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_W);
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DATA_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/btc_ctrl.sv =====
// Sequencer for the compensation steps and the word handshakes.
// Depends on btc_pkg for the command, status and step codes.
`timescale 1ns / 1ps

module btc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_cmd,
    output logic               in_ready,
    input  logic               out_ready,
    output logic               out_valid,
    input  btc_pkg::btc_stat_t stat,
    output btc_pkg::btc_cmd_t  cmd
);
    import btc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_DONE} state_t;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   out_valid_reg, out_valid_next;

    // Next state, next step and the commands of this cycle.
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = (in_cmd == CMD_PRESS) ? ST_P0 : ST_T0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                cmd.step = step_reg;
                case (step_reg)
                    ST_T3, ST_P13:
                        state_next = S_DONE;
                    ST_P8:
                    begin
                        if (stat.zero)
                            state_next = S_DONE;
                        else
                            step_next = step_reg + 1'b1;
                    end
                    ST_P9:
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    default:
                        step_next = step_reg + 1'b1;
                endcase
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_capture = 1'b1;
                    step_next       = ST_P10;
                    state_next      = S_EXEC;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= ST_T0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/btc_dp.sv =====
// Datapath: trim registers, fine temperature, one shared multiplier and the divider.
// Depends on btc_pkg and btc_div.
`timescale 1ns / 1ps

module btc_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [btc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [btc_pkg::TRIM_W-1:0] cfg_data,
    input  logic                       in_cmd,
    input  logic [btc_pkg::ADC_W-1:0]  in_adc,
    input  btc_pkg::btc_cmd_t          cmd,
    output btc_pkg::btc_stat_t         stat,
    output logic                       out_kind,
    output logic signed [btc_pkg::DATA_W-1:0] out_temp,
    output logic [btc_pkg::DATA_W-1:0] out_press,
    output logic                       out_zero
);
    import btc_pkg::*;

    logic [TRIM_W-1:0] temp_trim_reg, press_a_reg, press_b_reg, press_c_reg;
    logic [DATA_W-1:0] ft_reg, ft_next;

    logic [DATA_W-1:0] adc_reg;
    logic              kind_reg;
    logic [DATA_W-1:0] ra_reg, rb_reg, rx_reg, ry_reg, rq_reg, rt_reg, rp_reg, res_reg;
    logic [DATA_W-1:0] ra_next, rb_next, rx_next, ry_next, rq_next, rt_next, rp_next;
    logic [DATA_W-1:0] res_next;
    logic              zflag_reg, zflag_next;
    logic              okind_reg, ozero_reg;
    logic [DATA_W-1:0] ores_reg;

    logic [DATA_W-1:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [DATA_W-1:0] mul_a, mul_b, prod, diff;
    logic [DATA_W-1:0] div_dividend, div_quotient;
    logic              div_done;

    // Trim words unpacked from the packed registers.
    assign t1 = {16'd0, temp_trim_reg[15:0]};
    assign t2 = sx16(temp_trim_reg[31:16]);
    assign t3 = sx16(temp_trim_reg[47:32]);
    assign p1 = {16'd0, press_a_reg[15:0]};
    assign p2 = sx16(press_a_reg[31:16]);
    assign p3 = sx16(press_a_reg[47:32]);
    assign p4 = sx16(press_b_reg[15:0]);
    assign p5 = sx16(press_b_reg[31:16]);
    assign p6 = sx16(press_b_reg[47:32]);
    assign p7 = sx16(press_c_reg[15:0]);
    assign p8 = sx16(press_c_reg[31:16]);
    assign p9 = sx16(press_c_reg[47:32]);

    // Operand selection for the shared multiplier, low 32 bits kept.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        diff  = '0;
        case (cmd.step)
            ST_T0:
            begin
                mul_a = (adc_reg >> 3) - (t1 << 1);
                mul_b = t2;
            end
            ST_T1:
            begin
                diff  = (adc_reg >> 4) - t1;
                mul_a = diff;
                mul_b = diff;
            end
            ST_T2:
            begin
                mul_a = rb_reg;
                mul_b = t3;
            end
            ST_P1:
            begin
                mul_a = sra(rx_reg, 2);
                mul_b = sra(rx_reg, 2);
            end
            ST_P2:
            begin
                mul_a = sra(rq_reg, 11);
                mul_b = p6;
            end
            ST_P3:
            begin
                mul_a = rx_reg;
                mul_b = p5;
            end
            ST_P5:
            begin
                mul_a = p3;
                mul_b = sra(rq_reg, 13);
            end
            ST_P6:
            begin
                mul_a = p2;
                mul_b = rx_reg;
            end
            ST_P7:
            begin
                mul_a = K_P1_OFFSET + rx_reg;
                mul_b = p1;
            end
            ST_P8:
            begin
                mul_a = (K_ADC_SPAN - adc_reg) - sra(ry_reg, 12);
                mul_b = K_P_SCALE;
            end
            ST_P10:
            begin
                mul_a = rp_reg >> 3;
                mul_b = rp_reg >> 3;
            end
            ST_P11:
            begin
                mul_a = p9;
                mul_b = rt_reg;
            end
            ST_P12:
            begin
                mul_a = rp_reg >> 2;
                mul_b = p8;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = DATA_W'(mul_a * mul_b);

    // Register updates of each step.
    always_comb
    begin
        ft_next    = ft_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        rq_next    = rq_reg;
        rt_next    = rt_reg;
        rp_next    = rp_reg;
        res_next   = res_reg;
        zflag_next = zflag_reg;
        if (cmd.load)
        begin
            zflag_next = 1'b0;
        end
        else if (cmd.div_capture)
        begin
            rp_next = rp_reg[DATA_W-1] ? (div_quotient << 1) : div_quotient;
        end
        else if (cmd.exec)
        begin
            case (cmd.step)
                ST_T0:  ra_next = sra(prod, 11);
                ST_T1:  rb_next = sra(prod, 12);
                ST_T2:  ft_next = ra_reg + sra(prod, 14);
                ST_T3:  res_next = sra((ft_reg << 2) + ft_reg + K_T_ROUND, 8);
                ST_P0:  rx_next = sra(ft_reg, 1) - K_T_OFFSET;
                ST_P1:  rq_next = prod;
                ST_P2:  ry_next = prod;
                ST_P3:  ry_next = ry_reg + (prod << 1);
                ST_P4:  ry_next = sra(ry_reg, 2) + (p4 << 16);
                ST_P5:  rt_next = sra(prod, 3);
                ST_P6:  rx_next = sra(rt_reg + sra(prod, 1), 18);
                ST_P7:  rx_next = sra(prod, 15);
                ST_P8:
                begin
                    rp_next    = prod;
                    zflag_next = (rx_reg == '0);
                    res_next   = '0;
                end
                ST_P10: rt_next = prod >> 13;
                ST_P11: rx_next = sra(prod, 12);
                ST_P12: ry_next = sra(prod, 13);
                ST_P13: res_next = rp_reg + sra(rx_reg + ry_reg + p7, 4);
                default: res_next = res_reg;
            endcase
        end
    end

    // The dividend is doubled before the divide unless that would overflow.
    assign div_dividend = rp_reg[DATA_W-1] ? rp_reg : (rp_reg << 1);

    btc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (rx_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign stat.zero     = (rx_reg == '0);
    assign stat.div_done = div_done;

    // Trim registers and the fine temperature.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_trim_reg <= '0;
            press_a_reg   <= '0;
            press_b_reg   <= '0;
            press_c_reg   <= '0;
            ft_reg        <= '0;
        end
        else
        begin
            ft_reg <= ft_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TEMP_TRIM:    temp_trim_reg <= cfg_data;
                    REG_PRESS_TRIM_A: press_a_reg   <= cfg_data;
                    REG_PRESS_TRIM_B: press_b_reg   <= cfg_data;
                    REG_PRESS_TRIM_C: press_c_reg   <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    // Working registers and the output word.
    always_ff @(posedge clk)
    begin
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        rx_reg    <= rx_next;
        ry_reg    <= ry_next;
        rq_reg    <= rq_next;
        rt_reg    <= rt_next;
        rp_reg    <= rp_next;
        res_reg   <= res_next;
        zflag_reg <= zflag_next;
        if (cmd.load)
        begin
            adc_reg  <= {{(DATA_W-ADC_W){1'b0}}, in_adc};
            kind_reg <= in_cmd;
        end
        if (cmd.out_load)
        begin
            okind_reg <= kind_reg;
            ozero_reg <= zflag_reg;
            ores_reg  <= res_reg;
        end
    end

    assign out_kind  = okind_reg;
    assign out_zero  = ozero_reg;
    assign out_temp  = (okind_reg == CMD_PRESS) ? '0 : $signed(ores_reg);
    assign out_press = (okind_reg == CMD_PRESS) ? ores_reg : '0;

endmodule

// ===== rtl/baro_temp_compensation.sv =====
// Barometric temperature and pressure compensation, 32-bit integer scheme.
// Depends on btc_pkg, btc_if, btc_ctrl and btc_dp.
//
// Usage: a word on the sample channel carries a tag (cmd, 0 temperature,
// 1 pressure) and a 20-bit raw reading. Each accepted word gives one word on
// the result channel. A temperature word updates the stored fine temperature
// and returns hundredths of a degree; a pressure word uses the stored fine
// temperature and returns pascals, or 0 with zero_divisor set.
// Trim words are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while idle, as the block itself does not enforce it.
// A temperature word runs the temperature steps, a pressure word the 14
// pressure steps of the shared multiplier and the bit-serial divider, ending
// before the divider if the divisor is zero; each then loads the output register.
// Throughput: one word at a time; the next sample is accepted in the cycle
// after the result is loaded, so the divider sets the pressure rate.
// A finished result sits in an output register; the sample channel is open
// again while it waits, and the next result waits until it is taken.
// Reset clears the trim registers, the fine temperature and all handshakes.
`timescale 1ns / 1ps

module baro_temp_compensation (
    input  logic                          clk,
    input  logic                          rst_n,
    btc_sample_if.sink                    sample,
    btc_result_if.source                  result,
    input  logic                          cfg_we,
    input  logic [btc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [btc_pkg::TRIM_W-1:0]    cfg_data
);
    import btc_pkg::*;

    btc_cmd_t  cmd;
    btc_stat_t stat;

    btc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_cmd    (sample.cmd),
        .in_ready  (sample.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    btc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_cmd    (sample.cmd),
        .in_adc    (sample.raw_adc),
        .cmd       (cmd),
        .stat      (stat),
        .out_kind  (result.kind),
        .out_temp  (result.temperature_centi),
        .out_press (result.pressure_pa),
        .out_zero  (result.zero_divisor)
    );

endmodule

// ===== rtl/btc_checker.sv =====
// Port-level checks for the compensation block, bound to the top level.
// Depends on btc_pkg for the data width.
`timescale 1ns / 1ps

module btc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       out_kind,
    input logic [btc_pkg::DATA_W-1:0] out_press,
    input logic                       out_zero
);
    import btc_pkg::*;

    // A stalled result word stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // The block works on one sample at a time.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample accepted while busy");

    // A zero divisor only flags a pressure result of zero.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_zero |-> out_kind && (out_press == '0))
        else $error("zero divisor flag on a bad result");

    // A temperature result carries no pressure and no flag.
    a_temp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_kind |-> (out_press == '0) && !out_zero)
        else $error("temperature result with pressure fields set");

endmodule

bind baro_temp_compensation btc_checker u_btc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_kind  (result.kind),
    .out_press (result.pressure_pa),
    .out_zero  (result.zero_divisor)
);
